FILE: rtl/tst_pkg.sv
// ---------------------------------------------------------------------------
// Timer slot table package
// Beat types, command codes, decoded operations and sequencer states shared
// by the timer slot table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    localparam int MAX_OUT   = 16;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_CANCEL  = 3'd1;
    localparam logic [2:0] CMD_REFRESH = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;
    localparam logic [2:0] CMD_SPARE0  = 3'd6;
    localparam logic [2:0] CMD_SPARE1  = 3'd7;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_REJ  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] period;
        logic        recurring;
        logic        anchor_now;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  timer_slot;
        logic [1:0]  status;
        logic        earliest;
        logic [47:0] time_left;
        logic        none_pending;
        logic        last;
    } out_beat_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_CANCEL,
        OP_REFRESH,
        OP_RESET,
        OP_TICK,
        OP_QUERY,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic        slot_ok;
        logic [31:0] period;
        logic        recurring;
        logic        anchor_now;
    } cmd_t;

    typedef struct packed {
        logic [47:0] deadline;
        logic [31:0] period;
        logic        repeat_flag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_FIN,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/tst_fifo.sv
// ---------------------------------------------------------------------------
// Timer slot table queue
// Small first-in first-out buffer of register entries with full and empty.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tst_front.sv
// ---------------------------------------------------------------------------
// Timer slot table front end
// Accepts command beats, decodes them and checks the slot range, and queues
// the decoded commands for the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_front #(
    parameter int SLOTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tst_pkg::in_beat_t item,
    output logic                   full,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output tst_pkg::cmd_t          cmd
);

    localparam int CMDW = $bits(tst_pkg::cmd_t);

    tst_pkg::cmd_t  dec;
    logic           q_empty;
    logic [CMDW-1:0] q_rdata;

    always_comb
    begin
        dec.slot       = item.slot;
        dec.slot_ok    = (32'(item.slot) < SLOTS);
        dec.period     = item.period;
        dec.recurring  = item.recurring;
        dec.anchor_now = item.anchor_now;
        unique case (item.cmd)
            tst_pkg::CMD_ADD:     dec.op = tst_pkg::OP_ADD;
            tst_pkg::CMD_CANCEL:  dec.op = tst_pkg::OP_CANCEL;
            tst_pkg::CMD_REFRESH: dec.op = tst_pkg::OP_REFRESH;
            tst_pkg::CMD_RESET:   dec.op = tst_pkg::OP_RESET;
            tst_pkg::CMD_TICK:    dec.op = tst_pkg::OP_TICK;
            tst_pkg::CMD_QUERY:   dec.op = tst_pkg::OP_QUERY;
            default:              dec.op = tst_pkg::OP_BAD;
        endcase
    end

    tst_fifo #(
        .W     (CMDW),
        .DEPTH (tst_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (dec),
        .full  (full),
        .pop   (cmd_ready),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = q_rdata;

endmodule

`default_nettype wire

FILE: rtl/tst_back.sv
// ---------------------------------------------------------------------------
// Timer slot table sequencer
// Holds the slot table and millisecond counter, runs one decoded command at
// a time, scanning slots for add, query and tick, and emits result beats.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_back #(
    parameter int SLOTS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire tst_pkg::cmd_t   cmd,
    output logic                 res_push,
    output tst_pkg::out_beat_t   res,
    input  wire logic            res_full
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int XW = $clog2(SLOTS + 1);

    tst_pkg::state_t    state_reg, state_next, ret_reg, ret_next;
    tst_pkg::cmd_t      cmd_reg, cmd_next;
    tst_pkg::out_beat_t res_reg, res_next;
    logic [47:0]        now_reg, now_next;
    logic [SLOTS-1:0]   active_reg, active_next;
    logic [SLOTS-1:0]   taken_reg, taken_next;

    tst_pkg::entry_t    mem [SLOTS];
    tst_pkg::entry_t    rd_data_reg, mem_wd;
    logic [IW-1:0]      rd_addr, mem_wa;
    logic               mem_we;

    logic [XW-1:0]      idx_reg, idx_next;
    logic               cmp_v_reg, cmp_v_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               best_v_reg, best_v_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    tst_pkg::entry_t    best_ent_reg, best_ent_next;
    logic               found_free_reg, found_free_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               first_reg, first_next;
    logic               pend_v_reg, pend_v_next;
    logic [IW-1:0]      pend_idx_reg, pend_idx_next;
    logic [4:0]         cnt_reg, cnt_next;

    logic [IW-1:0]      slot_idx;
    logic [47:0]        new_dl;
    logic               act;
    tst_pkg::entry_t    ent;

    assign slot_idx = IW'(cmd_reg.slot);
    assign new_dl   = now_reg + 48'(cmd_reg.period);
    assign act      = active_reg[cmp_idx_reg];
    assign ent      = rd_data_reg;
    assign res      = res_reg;

    always_comb
    begin
        if (state_reg == tst_pkg::ST_READ)
        begin
            rd_addr = slot_idx;
        end
        else if (idx_reg < XW'(SLOTS))
        begin
            rd_addr = idx_reg[IW-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        now_next        = now_reg;
        active_next     = active_reg;
        taken_next      = taken_reg;
        idx_next        = idx_reg;
        cmp_v_next      = cmp_v_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_v_next     = best_v_reg;
        best_idx_next   = best_idx_reg;
        best_ent_next   = best_ent_reg;
        found_free_next = found_free_reg;
        free_idx_next   = free_idx_reg;
        first_next      = first_reg;
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        cnt_next        = cnt_reg;
        cmd_ready       = 1'b0;
        res_push        = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = slot_idx;
        mem_wd          = ent;

        unique case (state_reg)
            tst_pkg::ST_IDLE:
            begin
                cmd_ready       = 1'b1;
                idx_next        = '0;
                cmp_v_next      = 1'b0;
                best_v_next     = 1'b0;
                found_free_next = 1'b0;
                first_next      = 1'b1;
                res_next        = '0;
                res_next.last   = 1'b1;
                res_next.timer_slot = cmd.slot;
                ret_next        = tst_pkg::ST_IDLE;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    unique case (cmd.op)
                        tst_pkg::OP_ADD, tst_pkg::OP_QUERY:
                        begin
                            state_next = tst_pkg::ST_SCAN;
                        end
                        tst_pkg::OP_TICK:
                        begin
                            now_next    = now_reg + 48'd1;
                            taken_next  = '0;
                            cnt_next    = '0;
                            pend_v_next = 1'b0;
                            state_next  = tst_pkg::ST_SCAN;
                        end
                        tst_pkg::OP_CANCEL, tst_pkg::OP_REFRESH, tst_pkg::OP_RESET:
                        begin
                            if (cmd.slot_ok && active_reg[IW'(cmd.slot)])
                            begin
                                if (cmd.op == tst_pkg::OP_CANCEL)
                                begin
                                    active_next[IW'(cmd.slot)] = 1'b0;
                                    res_next.status = tst_pkg::STAT_OK;
                                    state_next = tst_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    state_next = tst_pkg::ST_READ;
                                end
                            end
                            else
                            begin
                                res_next.status = tst_pkg::STAT_REJ;
                                state_next = tst_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                            res_next.status = tst_pkg::STAT_REJ;
                            state_next = tst_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            tst_pkg::ST_READ:
            begin
                state_next = tst_pkg::ST_EXEC;
            end

            tst_pkg::ST_EXEC:
            begin
                mem_wa = slot_idx;
                if (cmd_reg.op == tst_pkg::OP_REFRESH)
                begin
                    mem_we          = 1'b1;
                    mem_wd.deadline = now_reg + 48'(ent.period);
                    res_next.status = tst_pkg::STAT_OK;
                end
                else if (cmd_reg.period == ent.period && !cmd_reg.anchor_now)
                begin
                    res_next.status = tst_pkg::STAT_REJ;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wd.period   = cmd_reg.period;
                    mem_wd.deadline = cmd_reg.anchor_now ? new_dl :
                        ent.deadline - 48'(ent.period) + 48'(cmd_reg.period);
                    res_next.status = tst_pkg::STAT_OK;
                end
                state_next = tst_pkg::ST_EMIT;
            end

            tst_pkg::ST_SCAN:
            begin
                if (idx_reg < XW'(SLOTS))
                begin
                    cmp_idx_next = idx_reg[IW-1:0];
                    cmp_v_next   = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    cmp_v_next = 1'b0;
                end
                if (cmp_v_reg)
                begin
                    case (cmd_reg.op)
                        tst_pkg::OP_ADD:
                        begin
                            if (!act && !found_free_reg)
                            begin
                                found_free_next = 1'b1;
                                free_idx_next   = cmp_idx_reg;
                            end
                            if (act && !found_free_reg && ent.deadline <= new_dl)
                            begin
                                first_next = 1'b0;
                            end
                            if (act && found_free_reg && ent.deadline < new_dl)
                            begin
                                first_next = 1'b0;
                            end
                        end
                        tst_pkg::OP_QUERY:
                        begin
                            if (act && (!best_v_reg || ent.deadline < best_ent_reg.deadline))
                            begin
                                best_v_next   = 1'b1;
                                best_idx_next = cmp_idx_reg;
                                best_ent_next = ent;
                            end
                        end
                        default:
                        begin
                            if (act && !taken_reg[cmp_idx_reg] && ent.deadline <= now_reg
                                && (!best_v_reg || ent.deadline < best_ent_reg.deadline))
                            begin
                                best_v_next   = 1'b1;
                                best_idx_next = cmp_idx_reg;
                                best_ent_next = ent;
                            end
                        end
                    endcase
                end
                if (idx_reg == XW'(SLOTS) && !cmp_v_reg)
                begin
                    state_next = tst_pkg::ST_FIN;
                end
            end

            tst_pkg::ST_FIN:
            begin
                idx_next    = '0;
                cmp_v_next  = 1'b0;
                best_v_next = 1'b0;
                res_next    = '0;
                ret_next    = tst_pkg::ST_IDLE;
                case (cmd_reg.op)
                    tst_pkg::OP_ADD:
                    begin
                        res_next.last = 1'b1;
                        if (!found_free_reg)
                        begin
                            res_next.status = tst_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_we                     = 1'b1;
                            mem_wa                     = free_idx_reg;
                            mem_wd.deadline            = new_dl;
                            mem_wd.period              = cmd_reg.period;
                            mem_wd.repeat_flag         = cmd_reg.recurring;
                            active_next[free_idx_reg]  = 1'b1;
                            res_next.timer_slot        = 4'(free_idx_reg);
                            res_next.earliest          = first_reg;
                        end
                        state_next = tst_pkg::ST_EMIT;
                    end
                    tst_pkg::OP_QUERY:
                    begin
                        res_next.kind = tst_pkg::KIND_QUERY;
                        res_next.last = 1'b1;
                        if (!best_v_reg)
                        begin
                            res_next.none_pending = 1'b1;
                        end
                        else
                        begin
                            res_next.timer_slot = 4'(best_idx_reg);
                            res_next.time_left  = (best_ent_reg.deadline > now_reg) ?
                                best_ent_reg.deadline - now_reg : 48'd0;
                        end
                        state_next = tst_pkg::ST_EMIT;
                    end
                    default:
                    begin
                        res_next.kind       = tst_pkg::KIND_EXPIRY;
                        res_next.timer_slot = 4'(pend_idx_reg);
                        if (best_v_reg)
                        begin
                            taken_next[best_idx_reg] = 1'b1;
                            if (best_ent_reg.repeat_flag)
                            begin
                                mem_we          = 1'b1;
                                mem_wa          = best_idx_reg;
                                mem_wd          = best_ent_reg;
                                mem_wd.deadline = now_reg + 48'(best_ent_reg.period);
                            end
                            else
                            begin
                                active_next[best_idx_reg] = 1'b0;
                            end
                            cnt_next      = cnt_reg + 5'd1;
                            pend_v_next   = 1'b1;
                            pend_idx_next = best_idx_reg;
                            if (pend_v_reg)
                            begin
                                ret_next = (cnt_reg + 5'd1 == 5'(tst_pkg::MAX_OUT)) ?
                                    tst_pkg::ST_FLUSH : tst_pkg::ST_SCAN;
                                state_next = tst_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = (cnt_reg + 5'd1 == 5'(tst_pkg::MAX_OUT)) ?
                                    tst_pkg::ST_FLUSH : tst_pkg::ST_SCAN;
                            end
                        end
                        else if (pend_v_reg)
                        begin
                            state_next = tst_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            state_next = tst_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            tst_pkg::ST_FLUSH:
            begin
                res_next            = '0;
                res_next.kind       = tst_pkg::KIND_EXPIRY;
                res_next.timer_slot = 4'(pend_idx_reg);
                res_next.last       = 1'b1;
                pend_v_next         = 1'b0;
                ret_next            = tst_pkg::ST_IDLE;
                state_next          = tst_pkg::ST_EMIT;
            end

            tst_pkg::ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tst_pkg::ST_IDLE;
            ret_reg        <= tst_pkg::ST_IDLE;
            now_reg        <= '0;
            active_reg     <= '0;
            taken_reg      <= '0;
            idx_reg        <= '0;
            cmp_v_reg      <= 1'b0;
            best_v_reg     <= 1'b0;
            found_free_reg <= 1'b0;
            pend_v_reg     <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            now_reg        <= now_next;
            active_reg     <= active_next;
            taken_reg      <= taken_next;
            idx_reg        <= idx_next;
            cmp_v_reg      <= cmp_v_next;
            best_v_reg     <= best_v_next;
            found_free_reg <= found_free_next;
            pend_v_reg     <= pend_v_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        free_idx_reg <= free_idx_next;
        first_reg    <= first_next;
        pend_idx_reg <= pend_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result beat pushed into a full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(tst_pkg::MAX_OUT))
        else $error("expiry count beyond limit");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> (state_reg != tst_pkg::ST_IDLE))
        else $error("pending expiry left behind at idle");

    a_add_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tst_pkg::ST_FIN && cmd_reg.op == tst_pkg::OP_ADD && found_free_reg)
        |=> active_reg[$past(free_idx_reg)])
        else $error("added slot not marked active");

endmodule

`default_nettype wire

FILE: rtl/timer_slot_table.sv
// ---------------------------------------------------------------------------
// Timer slot table
// Table of timer slots with a millisecond counter, driven by command beats.
// ---------------------------------------------------------------------------
// Commands enter through a queue port: a beat is taken when push is high and
// full is low. Results leave through a queue port: the oldest result is on
// result while empty is low and is taken when pop is high.
// A front end decodes commands into a two-entry queue; a sequencer carries
// out one command at a time and feeds a four-entry result queue.
// In the sequencer, cancel, unknown codes and commands on inactive slots go
// straight to the result beat; refresh and reset read the slot entry first.
// Add, query and tick scan every slot through the table memory's single read
// port. A tick with n due timers runs n + 1 scans, or n when n reaches
// MAX_OUT, and emits one expiry beat per due timer that a scan finds.
// Reset clears the counter and the active marks at once; no other clearing
// pass is needed. While the receiver stalls, the result queue fills, the
// sequencer holds its beat, and then the command queue fills and full rises.
// ---------------------------------------------------------------------------
`default_nettype none

module timer_slot_table #(
    parameter int SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tst_pkg::in_beat_t  item,
    output logic                    full,
    input  wire logic               pop,
    output tst_pkg::out_beat_t      result,
    output logic                    empty
);

    localparam int RESW = $bits(tst_pkg::out_beat_t);

    logic               cmd_valid;
    logic               cmd_ready;
    tst_pkg::cmd_t      cmd;
    logic               res_push;
    logic               res_full;
    tst_pkg::out_beat_t res;
    logic [RESW-1:0]    res_rdata;

    tst_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tst_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    tst_fifo #(
        .W     (RESW),
        .DEPTH (tst_pkg::RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = res_rdata;

endmodule

`default_nettype wire

FILE: test/tb_timer_slot_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Timer slot table testbench
// Drives command beats with random gaps, predicts every result beat from an
// internal copy of the timer table, and compares result beats field by field.
// ---------------------------------------------------------------------------
`default_nettype none

class timer_scoreboard;
    logic [47:0] now_ms;
    logic [47:0] due_at [16];
    logic [31:0] per_ms [16];
    bit          rearm  [16];
    bit          busy   [16];
    tst_pkg::out_beat_t pending [$];
    int          errors;

    function new();
        now_ms = '0;
        errors = 0;
        for (int i = 0; i < 16; i++)
        begin
            busy[i] = 0;
            rearm[i] = 0;
            due_at[i] = '0;
            per_ms[i] = '0;
        end
    endfunction

    function bit ahead(int a, int b);
        if (due_at[a] != due_at[b])
            return due_at[a] < due_at[b];
        return a < b;
    endfunction

    function int free_count();
        int n;
        n = 0;
        for (int i = 0; i < 16; i++)
            if (!busy[i])
                n++;
        return n;
    endfunction

    function void add_result(logic [1:0] kind, logic [3:0] ts, logic [1:0] st, bit ea,
                             logic [47:0] tl, bit np, bit la);
        tst_pkg::out_beat_t r;
        r.kind = kind;
        r.timer_slot = ts;
        r.status = st;
        r.earliest = ea;
        r.time_left = tl;
        r.none_pending = np;
        r.last = la;
        pending = {pending, r};
    endfunction

    function void note_command(tst_pkg::in_beat_t c);
        int f;
        int best;
        bit first;
        bit taken [16];
        int order [$];
        logic [1:0] st;
        f = -1;
        first = 1;
        st = tst_pkg::STAT_REJ;
        order = {};
        case (c.cmd)
            tst_pkg::CMD_ADD:
            begin
                for (int i = 15; i >= 0; i--)
                    if (!busy[i])
                        f = i;
                if (f < 0)
                    add_result(tst_pkg::KIND_STATUS, 4'd0, tst_pkg::STAT_FULL, 0, 0, 0, 1);
                else
                begin
                    due_at[f] = now_ms + c.period;
                    per_ms[f] = c.period;
                    rearm[f] = c.recurring;
                    busy[f] = 1;
                    for (int i = 0; i < 16; i++)
                        if (i != f && busy[i] && ahead(i, f))
                            first = 0;
                    add_result(tst_pkg::KIND_STATUS, 4'(f), tst_pkg::STAT_OK, first, 0, 0, 1);
                end
            end
            tst_pkg::CMD_CANCEL, tst_pkg::CMD_REFRESH, tst_pkg::CMD_RESET:
            begin
                if (busy[c.slot])
                begin
                    if (c.cmd == tst_pkg::CMD_CANCEL)
                    begin
                        busy[c.slot] = 0;
                        st = tst_pkg::STAT_OK;
                    end
                    else if (c.cmd == tst_pkg::CMD_REFRESH)
                    begin
                        due_at[c.slot] = now_ms + per_ms[c.slot];
                        st = tst_pkg::STAT_OK;
                    end
                    else if (!(c.period == per_ms[c.slot] && !c.anchor_now))
                    begin
                        if (c.anchor_now)
                            due_at[c.slot] = now_ms + c.period;
                        else
                            due_at[c.slot] = due_at[c.slot] - per_ms[c.slot] + c.period;
                        per_ms[c.slot] = c.period;
                        st = tst_pkg::STAT_OK;
                    end
                end
                add_result(tst_pkg::KIND_STATUS, c.slot, st, 0, 0, 0, 1);
            end
            tst_pkg::CMD_TICK:
            begin
                now_ms = now_ms + 48'd1;
                for (int i = 0; i < 16; i++)
                    taken[i] = 0;
                while (order.size() < tst_pkg::MAX_OUT)
                begin
                    best = -1;
                    for (int i = 0; i < 16; i++)
                        if (busy[i] && !taken[i] && due_at[i] <= now_ms)
                            if (best < 0 || ahead(i, best))
                                best = i;
                    if (best < 0)
                        break;
                    taken[best] = 1;
                    order = {order, best};
                end
                foreach (order[k])
                begin
                    if (rearm[order[k]])
                        due_at[order[k]] = now_ms + per_ms[order[k]];
                    else
                        busy[order[k]] = 0;
                    add_result(tst_pkg::KIND_EXPIRY, 4'(order[k]), tst_pkg::STAT_OK, 0, 0, 0,
                               k == order.size() - 1);
                end
            end
            tst_pkg::CMD_QUERY:
            begin
                best = -1;
                for (int i = 0; i < 16; i++)
                    if (busy[i] && (best < 0 || ahead(i, best)))
                        best = i;
                if (best < 0)
                    add_result(tst_pkg::KIND_QUERY, 4'd0, tst_pkg::STAT_OK, 0, 0, 1, 1);
                else
                    add_result(tst_pkg::KIND_QUERY, 4'(best), tst_pkg::STAT_OK, 0,
                               due_at[best] > now_ms ? due_at[best] - now_ms : 48'd0, 0, 1);
            end
            default:
                add_result(tst_pkg::KIND_STATUS, c.slot, tst_pkg::STAT_REJ, 0, 0, 0, 1);
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task check_result(tst_pkg::out_beat_t r);
        tst_pkg::out_beat_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result beat", 64'(r), 64'd0);
            return;
        end
        e = pending.pop_front();
        if (r.kind !== e.kind) report("kind", r.kind, e.kind);
        if (r.timer_slot !== e.timer_slot) report("timer_slot", r.timer_slot, e.timer_slot);
        if (r.status !== e.status) report("status", r.status, e.status);
        if (r.earliest !== e.earliest) report("earliest", r.earliest, e.earliest);
        if (r.time_left !== e.time_left) report("time_left", r.time_left, e.time_left);
        if (r.none_pending !== e.none_pending)
            report("none_pending", r.none_pending, e.none_pending);
        if (r.last !== e.last) report("last", r.last, e.last);
    endtask
endclass

module tb_timer_slot_table;
    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    tst_pkg::in_beat_t item = '0;
    tst_pkg::out_beat_t result;
    logic full;
    logic empty;
    longint cycles = 0;
    timer_scoreboard table_model;

    timer_slot_table u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .pop(pop), .result(result), .empty(empty)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task send_command(tst_pkg::in_beat_t c);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap)
                @(negedge clk);
        end
        push <= 1;
        item <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        table_model.note_command(c);
        @(negedge clk);
    endtask

    task wait_drain;
        push <= 0;
        @(negedge clk);
        while (table_model.pending.size() != 0)
            @(negedge clk);
    endtask

    task send_fields(logic [2:0] cmd, logic [3:0] slot, logic [31:0] period,
                     bit rec, bit fnow);
        tst_pkg::in_beat_t c;
        c.cmd = cmd;
        c.slot = slot;
        c.period = period;
        c.recurring = rec;
        c.anchor_now = fnow;
        send_command(c);
    endtask

    task send_random;
        tst_pkg::in_beat_t c;
        int r;
        r = $urandom_range(0, 99);
        c.slot = 4'($urandom_range(0, 15));
        c.recurring = 1'($urandom_range(0, 1));
        c.anchor_now = 1'($urandom_range(0, 1));
        c.period = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
        if (r < 25)
            c.cmd = tst_pkg::CMD_ADD;
        else if (r < 55)
            c.cmd = tst_pkg::CMD_TICK;
        else if (r < 65)
            c.cmd = tst_pkg::CMD_CANCEL;
        else if (r < 73)
            c.cmd = tst_pkg::CMD_REFRESH;
        else if (r < 83)
            c.cmd = tst_pkg::CMD_RESET;
        else if (r < 95)
            c.cmd = tst_pkg::CMD_QUERY;
        else
            c.cmd = ($urandom_range(0, 1) == 0) ? tst_pkg::CMD_SPARE0 : tst_pkg::CMD_SPARE1;
        if (c.cmd == tst_pkg::CMD_ADD && table_model.free_count() == 0
            && $urandom_range(0, 3) != 0)
            c.cmd = tst_pkg::CMD_CANCEL;
        send_command(c);
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                pop <= 0;
                repeat (gap)
                    @(negedge clk);
            end
            pop <= 1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            table_model.check_result(result);
        end
    end

    initial
    begin
        table_model = new();
        repeat (4)
            @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        send_fields(tst_pkg::CMD_QUERY, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_TICK, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_CANCEL, 4'd15, 0, 0, 0);
        send_fields(tst_pkg::CMD_ADD, 4'd0, 32'hFFFF_FFFF, 1, 1);
        send_fields(tst_pkg::CMD_ADD, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_ADD, 4'd0, 32'd2, 1, 0);
        send_fields(tst_pkg::CMD_QUERY, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_RESET, 4'd2, 32'd2, 1, 0);
        send_fields(tst_pkg::CMD_RESET, 4'd2, 32'd3, 0, 0);
        send_fields(tst_pkg::CMD_RESET, 4'd0, 32'd5, 0, 1);
        send_fields(tst_pkg::CMD_REFRESH, 4'd2, 0, 0, 0);
        send_fields(tst_pkg::CMD_REFRESH, 4'd9, 0, 0, 0);
        send_fields(tst_pkg::CMD_TICK, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_CANCEL, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_SPARE0, 4'hA, 32'h5555_AAAA, 1, 1);
        send_fields(tst_pkg::CMD_SPARE1, 4'h5, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_fields(tst_pkg::CMD_ADD, 4'd0, 32'd1, 1'(i & 1), 0);
        send_fields(tst_pkg::CMD_TICK, 4'd0, 0, 0, 0);
        send_fields(tst_pkg::CMD_TICK, 4'd0, 0, 0, 0);
        wait_drain();
        for (int n = 0; n < 300; n++)
        begin
            if (n == 150)
                wait_drain();
            send_random();
        end
        wait_drain();
        repeat (200)
            @(negedge clk);
        if (table_model.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
